[sv/mdff_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdff_pkg
// Shared types and constants of the mesh duplicate filter and forwarder.
// ----------------------------------------------------------------------------
package mdff_pkg;

    localparam int ENTRIES = 128;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 16;
    localparam int TIME_W  = 32;
    localparam int ID_W    = 8;
    localparam int HOPS_W  = 8;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(30000);
    localparam logic [ID_W-1:0]   NODE_RESET   = ID_W'(2);

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_NODE   = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

[sv/mesh_duplicate_filter_forwarder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_duplicate_filter_forwarder_unit
// Duplicate suppression ring for flooded mesh packets with forwarding decision.
//
//   channel   direction  handshake                 payload
//   packet    in         i_in_valid / o_in_ready   source, dest, hops, seq, now
//   result    out        o_out_valid / i_out_ready duplicate, forward, hops, mine
//   config    in         psel/penable/pwrite/pready window_ms, node_id
//
// an item passes in order through the accept step, a ram read per entry, the
// emptying of the compare stage, then a write-back step and a result step
// the ring ram has one port, so scan and write-back never overlap
// reset needs no clearing pass: a fill count marks entries not yet written
// a stalled result is held in the output register while the next item scans
// ----------------------------------------------------------------------------
module mesh_duplicate_filter_forwarder_unit
    import mdff_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [ID_W-1:0]   i_source_id,
    input  logic [ID_W-1:0]   i_dest_id,
    input  logic [HOPS_W-1:0] i_hops_left,
    input  logic [7:0]        i_sequence_low,
    input  logic [TIME_W-1:0] i_now_ms,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_duplicate,
    output logic              o_forward,
    output logic [HOPS_W-1:0] o_forward_hops,
    output logic              o_for_this_node,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [KEY_W-1:0]  r_key, n_key;
    logic [ID_W-1:0]   r_dst, n_dst;
    logic [HOPS_W-1:0] r_hops, n_hops;
    logic [TIME_W-1:0] r_now, n_now;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic              r_dup, n_dup;
    logic [IDX_W-1:0]  r_wptr, n_wptr;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [TIME_W-1:0] r_window, n_window;
    logic [ID_W-1:0]   r_node, n_node;
    logic              r_out_valid, n_out_valid;
    logic              r_out_dup, n_out_dup;
    logic              r_out_fwd, n_out_fwd;
    logic [HOPS_W-1:0] r_out_hops, n_out_hops;
    logic              r_out_mine, n_out_mine;

    logic              ram_we;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_addr;
    t_entry            ram_wdata;
    t_entry            ram_rdata;

    logic              cfg_we;
    logic              entry_vld;
    logic [KEY_W-1:0]  rd_key;
    logic [TIME_W-1:0] rd_stamp;
    logic [TIME_W-1:0] age;
    logic              hit;
    logic              mine;
    logic              fwd;
    logic              out_free;

    mdff_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign ram_re    = (r_state == S_SCAN) && (r_cnt < CNT_W'(ENTRIES));
    assign ram_we    = (r_state == S_WRITE) && !r_dup;
    assign ram_addr  = (r_state == S_WRITE) ? r_wptr : r_cnt[IDX_W-1:0];
    assign ram_wdata = '{key: r_key, stamp: r_now};

    // entries past the fill count are read as zero, whatever the ram holds there
    assign entry_vld = CNT_W'(r_cmp_idx) < r_fill;
    assign rd_key    = entry_vld ? ram_rdata.key : '0;
    assign rd_stamp  = entry_vld ? ram_rdata.stamp : '0;
    assign age       = r_now - rd_stamp;
    assign hit       = r_cmp_vld && (rd_key == r_key) && (age < r_window);

    assign mine      = (r_dst == r_node);
    assign fwd       = !r_dup && !mine && (r_hops != '0);
    assign out_free  = !r_out_valid || i_out_ready;

    assign cfg_we    = psel && penable && pwrite && pready;

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_dst       = r_dst;
        n_hops      = r_hops;
        n_now       = r_now;
        n_cnt       = r_cnt;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_idx   = r_cmp_idx;
        n_dup       = r_dup;
        n_wptr      = r_wptr;
        n_fill      = r_fill;
        n_window    = r_window;
        n_node      = r_node;
        n_out_valid = r_out_valid;
        n_out_dup   = r_out_dup;
        n_out_fwd   = r_out_fwd;
        n_out_hops  = r_out_hops;
        n_out_mine  = r_out_mine;

        if (cfg_we) begin
            case (paddr[2])
                REG_WINDOW: n_window = pwdata[TIME_W-1:0];
                REG_NODE:   n_node   = pwdata[ID_W-1:0];
                default:    n_node   = r_node;
            endcase
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key     = {i_source_id, i_sequence_low};
                    n_dst     = i_dest_id;
                    n_hops    = i_hops_left;
                    n_now     = i_now_ms;
                    n_cnt     = '0;
                    n_cmp_vld = 1'b0;
                    n_dup     = 1'b0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                n_cmp_vld = ram_re;
                n_cmp_idx = r_cnt[IDX_W-1:0];
                n_dup     = r_dup || hit;
                if (ram_re) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end else if (!r_cmp_vld) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (!r_dup) begin
                    n_wptr = (r_wptr == IDX_W'(ENTRIES - 1)) ? '0 : r_wptr + IDX_W'(1);
                    if (r_fill < CNT_W'(ENTRIES)) begin
                        n_fill = r_fill + CNT_W'(1);
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_dup   = r_dup;
                    n_out_fwd   = fwd;
                    n_out_hops  = fwd ? r_hops - HOPS_W'(1) : '0;
                    n_out_mine  = mine;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_vld   <= 1'b0;
            r_wptr      <= '0;
            r_fill      <= '0;
            r_window    <= WINDOW_RESET;
            r_node      <= NODE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_key       <= n_key;
            r_dst       <= n_dst;
            r_hops      <= n_hops;
            r_now       <= n_now;
            r_cnt       <= n_cnt;
            r_cmp_vld   <= n_cmp_vld;
            r_cmp_idx   <= n_cmp_idx;
            r_dup       <= n_dup;
            r_wptr      <= n_wptr;
            r_fill      <= n_fill;
            r_window    <= n_window;
            r_node      <= n_node;
            r_out_valid <= n_out_valid;
            r_out_dup   <= n_out_dup;
            r_out_fwd   <= n_out_fwd;
            r_out_hops  <= n_out_hops;
            r_out_mine  <= n_out_mine;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_duplicate     = r_out_dup;
    assign o_forward       = r_out_fwd;
    assign o_forward_hops  = r_out_hops;
    assign o_for_this_node = r_out_mine;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NODE) ? DATA_W'(r_node) : DATA_W'(r_window);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a scan was running");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(ENTRIES))
        else $error("fill count beyond ring depth");

    a_no_write_on_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_WRITE) && !r_dup && !ram_re)
        else $error("ring written for a duplicate or during scan");

    a_dup_no_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_duplicate || !o_forward)) |-> !o_forward ||
            (o_forward_hops == '0 && !o_forward))
        else $error("duplicate item marked for forwarding");

    a_hops_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_forward) |-> (o_forward_hops == '0))
        else $error("hop count given for an item not forwarded");

endmodule

[sv/mdff_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdff_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mdff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[test/dup_filter_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dup_filter_checker
// Watches the packet, result and register channels of the mesh duplicate
// filter. It keeps its own copy of the key ring and of the registers, works
// out the verdict of every accepted packet, and compares each accepted result
// field by field with the oldest verdict still due.
// ----------------------------------------------------------------------------
module dup_filter_checker
    import mdff_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              o_in_ready,
    input  logic [ID_W-1:0]   i_source_id,
    input  logic [ID_W-1:0]   i_dest_id,
    input  logic [HOPS_W-1:0] i_hops_left,
    input  logic [7:0]        i_sequence_low,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic              o_duplicate,
    input  logic              o_forward,
    input  logic [HOPS_W-1:0] o_forward_hops,
    input  logic              o_for_this_node,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    output int                mismatches,
    output int                waiting
);

    typedef struct packed {
        logic              dup;
        logic              fwd;
        logic [HOPS_W-1:0] fwd_hops;
        logic              mine;
    } t_packet_verdict;

    logic [KEY_W-1:0]  seen_key   [ENTRIES];
    logic [TIME_W-1:0] seen_stamp [ENTRIES];
    logic [IDX_W-1:0]  ring_head;
    logic [TIME_W-1:0] window_ms;
    logic [ID_W-1:0]   node_id;
    t_packet_verdict   verdicts_due[$];

    // search the ring, store the key if it is new, decide on forwarding
    function automatic t_packet_verdict judge_packet(
        input logic [ID_W-1:0]   src,
        input logic [ID_W-1:0]   dst,
        input logic [HOPS_W-1:0] hops,
        input logic [7:0]        seq,
        input logic [TIME_W-1:0] now
    );
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] age;
        t_packet_verdict   v;
        key   = {src, seq};
        v     = '0;
        v.mine = (dst == node_id);
        for (int k = 0; k < ENTRIES; k++) begin
            age = now - seen_stamp[k];
            if (seen_key[k] == key && age < window_ms) begin
                v.dup = 1'b1;
            end
        end
        if (!v.dup) begin
            seen_key[ring_head]   = key;
            seen_stamp[ring_head] = now;
            ring_head = (ring_head == IDX_W'(ENTRIES - 1)) ? '0 : ring_head + IDX_W'(1);
        end
        v.fwd = !v.dup && !v.mine && (hops != '0);
        if (v.fwd) begin
            v.fwd_hops = hops - HOPS_W'(1);
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_packet_verdict want;
        if (!i_rst_n) begin
            for (int k = 0; k < ENTRIES; k++) begin
                seen_key[k]   = '0;
                seen_stamp[k] = '0;
            end
            ring_head = '0;
            window_ms = WINDOW_RESET;
            node_id   = NODE_RESET;
            verdicts_due.delete();
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (verdicts_due.size() == 0) begin
                    $error("result item with no packet pending");
                    mismatches <= mismatches + 1;
                end else begin
                    want = verdicts_due.pop_front();
                    if (o_duplicate !== want.dup || o_forward !== want.fwd ||
                        o_forward_hops !== want.fwd_hops ||
                        o_for_this_node !== want.mine) begin
                        mismatches <= mismatches + 1;
                    end
                    if (o_duplicate !== want.dup)
                        $error("duplicate: expected %0d, got %0d", want.dup, o_duplicate);
                    if (o_forward !== want.fwd)
                        $error("forward: expected %0d, got %0d", want.fwd, o_forward);
                    if (o_forward_hops !== want.fwd_hops)
                        $error("forward_hops: expected %0d, got %0d",
                               want.fwd_hops, o_forward_hops);
                    if (o_for_this_node !== want.mine)
                        $error("for_this_node: expected %0d, got %0d",
                               want.mine, o_for_this_node);
                end
            end
            if (i_in_valid && o_in_ready) begin
                verdicts_due.push_back(judge_packet(i_source_id, i_dest_id, i_hops_left,
                                                    i_sequence_low, i_now_ms));
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    REG_WINDOW: window_ms = pwdata[TIME_W-1:0];
                    REG_NODE:   node_id   = pwdata[ID_W-1:0];
                    default: ;
                endcase
            end
        end
        waiting <= verdicts_due.size();
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the mesh duplicate filter and forwarder. A directed run covers
// the cleared ring, wrapping ages, zero and full windows and the hop count
// limits; random phases then replay packets from a small pool of sources and
// sequence bytes under changing window and node settings, with bursty input
// and a stalling result receiver. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import mdff_pkg::*;

    localparam int STALL_LIMIT     = 4000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 120;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_in_valid      = 1'b0;
    logic              o_in_ready;
    logic [ID_W-1:0]   i_source_id     = '0;
    logic [ID_W-1:0]   i_dest_id       = '0;
    logic [HOPS_W-1:0] i_hops_left     = '0;
    logic [7:0]        i_sequence_low  = '0;
    logic [TIME_W-1:0] i_now_ms        = '0;
    logic              o_out_valid;
    logic              i_out_ready     = 1'b0;
    logic              o_duplicate;
    logic              o_forward;
    logic [HOPS_W-1:0] o_forward_hops;
    logic              o_for_this_node;
    logic              psel            = 1'b0;
    logic              penable         = 1'b0;
    logic              pwrite          = 1'b0;
    logic [ADDR_W-1:0] paddr           = '0;
    logic [DATA_W-1:0] pwdata          = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int                mismatches;
    int                waiting;
    logic              steady     = 1'b0;
    int                burst_left = 0;
    int                ready_hold = 0;
    logic [TIME_W-1:0] clock_ms   = '0;
    logic [ID_W-1:0]   cur_node   = NODE_RESET;

    mesh_duplicate_filter_forwarder_unit DUT (.*);

    dup_filter_checker u_checker (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result receiver: always ready when steady, else mostly ready, short random stalls, now and then a long one
    always @(posedge i_clk) begin
        if (steady) begin
            i_out_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold  <= ready_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            case ($urandom_range(0, 19))
                0: begin
                    ready_hold  <= $urandom_range(1, 250);
                    i_out_ready <= 1'b0;
                end
                1, 2, 3, 4, 5: i_out_ready <= 1'b0;
                default:       i_out_ready <= 1'b1;
            endcase
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (psel && penable && pwrite && pready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_NODE) cur_node = value[ID_W-1:0];
    endtask

    task automatic send_packet(
        input logic [ID_W-1:0]   src,
        input logic [ID_W-1:0]   dst,
        input logic [HOPS_W-1:0] hops,
        input logic [7:0]        seq,
        input logic [TIME_W-1:0] now
    );
        int gap;
        if (burst_left == 0) begin
            if (steady) begin
                gap = 0;
            end else if ($urandom_range(0, 9) == 0) begin
                gap = $urandom_range(20, 150);
            end else begin
                gap = $urandom_range(0, 3);
            end
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        i_in_valid     <= 1'b1;
        i_source_id    <= src;
        i_dest_id      <= dst;
        i_hops_left    <= hops;
        i_sequence_low <= seq;
        i_now_ms       <= now;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        burst_left--;
    endtask

    // stop sending and wait for every pending result
    task automatic drain;
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (waiting != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_random_packet;
        logic [ID_W-1:0]   src;
        logic [ID_W-1:0]   dst;
        logic [7:0]        seq;
        logic [HOPS_W-1:0] hops;
        if ($urandom_range(0, 9) < 7) begin
            src = ID_W'($urandom_range(0, 7));
            seq = 8'($urandom_range(0, 15));
            case ($urandom_range(0, 2))
                0:       dst = cur_node;
                1:       dst = ID_W'($urandom_range(0, 7));
                default: dst = ID_W'($urandom);
            endcase
            hops = HOPS_W'($urandom_range(0, 7));
            if ($urandom_range(0, 49) == 0) begin
                clock_ms = $urandom;
            end else begin
                clock_ms = clock_ms + $urandom_range(0, 1500);
            end
            send_packet(src, dst, hops, seq, clock_ms);
        end else begin
            send_packet(ID_W'($urandom), ID_W'($urandom), HOPS_W'($urandom),
                        8'($urandom), $urandom);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // cleared ring holds key 0 at stamp 0
        send_packet(8'h00, 8'h05, 8'h03, 8'h00, 32'h0000_0000);
        send_packet(8'h00, 8'h05, 8'h03, 8'h00, 32'h0000_752F);
        send_packet(8'h00, 8'h02, 8'h03, 8'h00, 32'h0000_7530);
        send_packet(8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        // age wraps past zero
        send_packet(8'hFF, 8'h00, 8'h01, 8'hFF, 32'h0000_0010);
        send_packet(8'h01, 8'h00, 8'h00, 8'h01, 32'h0000_0064);
        send_packet(8'h01, 8'h02, 8'h01, 8'h01, 32'h0000_00C8);
        send_packet(8'h02, 8'h01, 8'h01, 8'h80, 32'h0000_012C);
        send_packet(8'hAA, 8'h55, 8'h80, 8'h55, 32'h8000_0000);
        send_packet(8'h55, 8'hAA, 8'h7F, 8'hAA, 32'h7FFF_FFFF);
        drain();

        // zero window: nothing is a duplicate
        write_reg(REG_WINDOW, 32'h0000_0000);
        write_reg(REG_NODE, 32'h0000_00FF);
        send_packet(8'h01, 8'hFF, 8'h02, 8'h01, 32'h0000_0200);
        send_packet(8'h01, 8'hFE, 8'h02, 8'h01, 32'h0000_0200);
        send_packet(8'h00, 8'hFE, 8'h01, 8'h00, 32'h0000_0000);
        drain();

        // full window: any matching key except the very oldest age
        write_reg(REG_WINDOW, 32'hFFFF_FFFF);
        write_reg(REG_NODE, 32'h0000_0000);
        send_packet(8'hFF, 8'h00, 8'h09, 8'hFF, 32'hFFFF_FFFE);
        send_packet(8'h00, 8'h01, 8'h09, 8'h00, 32'h1234_5678);
        send_packet(8'h02, 8'h03, 8'hFF, 8'h80, 32'h0000_0000);
        send_packet(8'h02, 8'h00, 8'hFF, 8'h80, 32'hFFFF_FFFF);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            steady = (p == 2 || p == 5);
            case (p)
                0: begin
                    write_reg(REG_WINDOW, WINDOW_RESET);
                    write_reg(REG_NODE, DATA_W'(NODE_RESET));
                end
                1: begin
                    write_reg(REG_WINDOW, 32'd1);
                    write_reg(REG_NODE, 32'd0);
                end
                2: begin
                    write_reg(REG_WINDOW, $urandom_range(100, 3000));
                    write_reg(REG_NODE, 32'd255);
                end
                3: begin
                    write_reg(REG_WINDOW, 32'd0);
                    write_reg(REG_NODE, $urandom_range(0, 255));
                end
                4: begin
                    write_reg(REG_WINDOW, 32'hFFFF_FFFF);
                    write_reg(REG_NODE, $urandom_range(0, 7));
                end
                5: begin
                    write_reg(REG_WINDOW, $urandom);
                    write_reg(REG_NODE, 32'd3);
                end
                6: begin
                    write_reg(REG_WINDOW, $urandom_range(500, 5000));
                    write_reg(REG_NODE, 32'd1);
                end
                default: begin
                    write_reg(REG_WINDOW, WINDOW_RESET);
                    write_reg(REG_NODE, $urandom_range(0, 255));
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_random_packet();
            end
            drain();
        end

        steady = 1'b0;
        repeat (ENTRIES + 8) @(posedge i_clk);
        if (mismatches == 0 && waiting == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
sv/mdff_pkg.sv
sv/mdff_ram.sv
sv/mesh_duplicate_filter_forwarder_unit.sv
test/dup_filter_checker.sv
test/tb.sv
